[hdl/eps_pkg.sv]
// Shared types, codes and device tables for the EEPROM page-write splitter.
`timescale 1ns / 1ps

package eps_pkg;

    // Request codes carried by the action field of an input beat.
    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_TYPE = 1'b0;
    localparam logic CFG_BUS_ADDRESS = 1'b1;

    localparam logic [3:0] DEVICE_TYPE_RESET = 4'd8;
    localparam logic [7:0] BUS_ADDRESS_RESET = 8'd160;

    // Per-device information derived from the configuration registers.
    typedef struct packed {
        logic        known;
        logic [7:0]  page;
        logic [16:0] capacity;
        logic [1:0]  addr_bytes;
        logic [7:0]  dev_addr;
    } t_dev_info;

    // One result beat.
    typedef struct packed {
        logic        seg_valid;
        logic [15:0] seg_address;
        logic [15:0] seg_length;
        logic [15:0] buffer_offset;
        logic [1:0]  addr_bytes;
        logic [7:0]  dev_addr;
        logic        last;
        logic        range_error;
    } t_result;

    // Page size in bytes for each size code.
    function automatic logic [7:0] page_size(input logic [3:0] code);
        logic [7:0] p;
        case (code)
            4'd0, 4'd1:       p = 8'd8;
            4'd2, 4'd3, 4'd4: p = 8'd16;
            4'd5, 4'd6:       p = 8'd32;
            4'd7, 4'd8:       p = 8'd64;
            4'd9:             p = 8'd128;
            default:          p = 8'd8;
        endcase
        return p;
    endfunction

    // Capacity in bytes for each size code.
    function automatic logic [16:0] capacity_of(input logic [3:0] code);
        logic [16:0] c;
        case (code)
            4'd0:    c = 17'd128;
            4'd1:    c = 17'd256;
            4'd2:    c = 17'd512;
            4'd3:    c = 17'd1024;
            4'd4:    c = 17'd2048;
            4'd5:    c = 17'd4096;
            4'd6:    c = 17'd8192;
            4'd7:    c = 17'd16384;
            4'd8:    c = 17'd32768;
            4'd9:    c = 17'd65536;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

endpackage

[hdl/eps_cfg.sv]
// Configuration registers and device table lookup for the page-write splitter.
`timescale 1ns / 1ps

module eps_cfg #(
    parameter int ADDRESS_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output eps_pkg::t_dev_info  o_info
);
    import eps_pkg::*;

    localparam logic [16:0] ADDR_LIMIT = 17'(1) << ADDRESS_WIDTH;

    logic [3:0]  r_device_type;
    logic [7:0]  r_bus_address;
    logic [16:0] table_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_type <= DEVICE_TYPE_RESET;
            r_bus_address <= BUS_ADDRESS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEVICE_TYPE: r_device_type <= i_cfg_data[3:0];
                CFG_BUS_ADDRESS: r_bus_address <= i_cfg_data;
                default:         r_bus_address <= r_bus_address;
            endcase
        end
    end

    always_comb begin
        table_cap         = capacity_of(r_device_type);
        o_info.known      = (r_device_type < 4'd10);
        o_info.page       = page_size(r_device_type);
        o_info.capacity   = (table_cap < ADDR_LIMIT) ? table_cap : ADDR_LIMIT;
        o_info.addr_bytes = (r_device_type < 4'd2) ? 2'd1 : 2'd2;
        o_info.dev_addr   = r_bus_address;
    end

endmodule

[hdl/eps_plan.sv]
// Request state and segment planning logic for the page-write splitter.
`timescale 1ns / 1ps

module eps_plan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  eps_pkg::t_action    i_action,
    input  logic [15:0]         i_start_address,
    input  logic [15:0]         i_byte_count,
    input  eps_pkg::t_dev_info  i_info,
    output eps_pkg::t_result    o_result
);
    import eps_pkg::*;

    logic [16:0] r_next_address, n_next_address;
    logic [16:0] r_bytes_left,   n_bytes_left;
    logic [15:0] r_offset,       n_offset;
    logic        r_active,       n_active;

    logic [16:0] req_end;
    logic        req_bad;
    logic [16:0] base_addr;
    logic [16:0] base_left;
    logic [15:0] base_off;
    logic [7:0]  room;
    logic [7:0]  len;
    logic        emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_address <= '0;
            r_bytes_left   <= '0;
            r_offset       <= '0;
            r_active       <= 1'b0;
        end else if (i_fire) begin
            r_next_address <= n_next_address;
            r_bytes_left   <= n_bytes_left;
            r_offset       <= n_offset;
            r_active       <= n_active;
        end
    end

    always_comb begin
        req_end = {1'b0, i_start_address} + {1'b0, i_byte_count};
        req_bad = !i_info.known || (req_end > i_info.capacity);

        // A write start plans from the request, an advance from the saved state.
        if (i_action == ACT_WRITE) begin
            base_addr = {1'b0, i_start_address};
            base_left = {1'b0, i_byte_count};
            base_off  = '0;
        end else begin
            base_addr = r_next_address;
            base_left = r_bytes_left;
            base_off  = r_offset;
        end
        room = i_info.page - (base_addr[7:0] & (i_info.page - 8'd1));
        len  = (base_left < {9'd0, room}) ? base_left[7:0] : room;

        n_next_address = r_next_address;
        n_bytes_left   = r_bytes_left;
        n_offset       = r_offset;
        n_active       = r_active;
        emit           = 1'b0;

        o_result             = '0;
        o_result.addr_bytes  = i_info.addr_bytes;
        o_result.dev_addr    = i_info.dev_addr;

        case (i_action)
            ACT_WRITE: begin
                n_active = 1'b0;
                if (req_bad) begin
                    o_result.range_error = 1'b1;
                end else if (i_byte_count == 16'd0) begin
                    o_result.last = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            ACT_READ: begin
                if (req_bad) begin
                    o_result.range_error = 1'b1;
                end else if (i_byte_count == 16'd0) begin
                    o_result.last = 1'b1;
                end else begin
                    o_result.seg_valid   = 1'b1;
                    o_result.seg_address = i_start_address;
                    o_result.seg_length  = i_byte_count;
                    o_result.last        = 1'b1;
                end
            end
            ACT_ADVANCE: begin
                if (r_active) begin
                    if (!i_info.known) begin
                        n_active             = 1'b0;
                        o_result.range_error = 1'b1;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        if (emit) begin
            n_next_address         = base_addr + {9'd0, len};
            n_bytes_left           = base_left - {9'd0, len};
            n_offset               = base_off + {8'd0, len};
            n_active               = (n_bytes_left != 17'd0);
            o_result.seg_valid     = 1'b1;
            o_result.seg_address   = base_addr[15:0];
            o_result.seg_length    = {8'd0, len};
            o_result.buffer_offset = base_off;
            o_result.last          = (n_bytes_left == 17'd0);
        end
    end

endmodule

[hdl/eeprom_page_write_splitter.sv]
// Top level of the serial-EEPROM page-write splitter: beat registers and handshakes.
`timescale 1ns / 1ps

// The splitter plans bus transfers for a serial EEPROM of the configured size
// code. A write start is range-checked against the device capacity and, if it
// fits, gives its first segment at once; every advance beat then releases the
// next segment, each one kept within a single page, until a segment with the
// last flag ends the request. A read start gives one segment for the whole
// count. Every input beat yields exactly one result beat, with range_error set
// when the request does not fit or the size code is unknown. While the output
// is not stalled the block takes one beat per cycle: a beat passes from the
// input register through the planning logic into the output register, which
// drives the output ports, and the input side keeps accepting while a result
// waits as long as the output register can move on. The configuration port is
// always ready; registers should only be written while no beat is in flight.

module eeprom_page_write_splitter #(
    parameter int ADDRESS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_start_address,
    input  logic [15:0] i_byte_count,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_segment_valid,
    output logic [15:0] o_segment_address,
    output logic [15:0] o_segment_length,
    output logic [15:0] o_buffer_offset,
    output logic [1:0]  o_address_bytes,
    output logic [7:0]  o_device_address,
    output logic        o_last_segment,
    output logic        o_range_error
);
    import eps_pkg::*;

    // Input register.
    logic        r_in_valid;
    t_action     r_action;
    logic [15:0] r_start_address;
    logic [15:0] r_byte_count;

    // Output register.
    logic        r_out_valid;
    t_result     r_out;

    t_dev_info   info;
    t_result     result;
    logic        out_ready;
    logic        fire;
    logic        in_ready;
    logic        in_take;

    // The output register can load when it is empty or its beat leaves now.
    // The input register can load when it is empty or its beat moves on now.
    assign out_ready = !r_out_valid || !i_out_stall;
    assign fire      = r_in_valid && out_ready;
    assign in_ready  = !r_in_valid || fire;
    assign in_take   = i_in_valid && in_ready;

    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = 1'b1;

    eps_cfg #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (info)
    );

    // The request state advances only when a beat really moves into the
    // output register, so a stall never replays or skips a segment.
    eps_plan u_plan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_action        (r_action),
        .i_start_address (r_start_address),
        .i_byte_count    (r_byte_count),
        .i_info          (info),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action        <= t_action'(i_action);
            r_start_address <= i_start_address;
            r_byte_count    <= i_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_segment_valid   = r_out.seg_valid;
    assign o_segment_address = r_out.seg_address;
    assign o_segment_length  = r_out.seg_length;
    assign o_buffer_offset   = r_out.buffer_offset;
    assign o_address_bytes   = r_out.addr_bytes;
    assign o_device_address  = r_out.dev_addr;
    assign o_last_segment    = r_out.last;
    assign o_range_error     = r_out.range_error;

endmodule

[hdl/eps_checker.sv]
// Port-level checks for the page-write splitter, bound to its top level.
`timescale 1ns / 1ps

module eps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_segment_valid,
    input logic [15:0] o_segment_address,
    input logic [15:0] o_segment_length,
    input logic [15:0] o_buffer_offset,
    input logic [1:0]  o_address_bytes,
    input logic        o_last_segment,
    input logic        o_range_error
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat withdrawn while stalled");

    // A dropped request describes no segment and does not end a write.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> !o_segment_valid && !o_last_segment)
        else $error("range error beat carries a segment or last flag");

    // Without a segment the segment fields read zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_segment_valid |->
            o_segment_address == 16'd0 && o_segment_length == 16'd0 &&
            o_buffer_offset == 16'd0)
        else $error("segment fields not cleared on a beat without a segment");

    // A real segment always moves at least one byte.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_segment_valid |-> o_segment_length != 16'd0)
        else $error("segment of zero length");

    // Address byte count is one or two.
    a_addr_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_address_bytes == 2'd1 || o_address_bytes == 2'd2)
        else $error("address byte count out of range");

endmodule

bind eeprom_page_write_splitter eps_checker u_eps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_segment_valid   (o_segment_valid),
    .o_segment_address (o_segment_address),
    .o_segment_length  (o_segment_length),
    .o_buffer_offset   (o_buffer_offset),
    .o_address_bytes   (o_address_bytes),
    .o_last_segment    (o_last_segment),
    .o_range_error     (o_range_error)
);
